FILE: rtl/core/ocrfw_pkg.sv
`timescale 1ns / 1ps
// Package for the full-width text normalizer: code point constants,
// the command passed from the classifier to the emitter, and helper functions.
// No dependencies.
package ocrfw_pkg;

    localparam int CpW = 21;
    localparam int QDepth = 4;
    localparam int QPtrW = $clog2(QDepth);
    localparam int QCntW = $clog2(QDepth + 1);

    localparam logic [CpW-1:0] CP_PERIOD    = 21'h00002E;
    localparam logic [CpW-1:0] CP_MIDDOT    = 21'h0030FB;
    localparam logic [CpW-1:0] CP_FW_PERIOD = 21'h00FF0E;
    localparam logic [CpW-1:0] CP_ELLIPSIS  = 21'h002026;
    localparam logic [CpW-1:0] CP_QUOTE     = 21'h000022;
    localparam logic [CpW-1:0] CP_APOS      = 21'h000027;
    localparam logic [CpW-1:0] CP_BACKTICK  = 21'h000060;
    localparam logic [CpW-1:0] CP_ASCII_LO  = 21'h000021;
    localparam logic [CpW-1:0] CP_ASCII_HI  = 21'h00007E;
    localparam logic [CpW-1:0] FW_OFFSET    = 21'h00FEE0;

    typedef struct packed {
        logic           lead;
        logic           lead_is_period;
        logic [1:0]     body_cnt;
        logic           body_single;
        logic [CpW-1:0] body_cp;
    } cmd_t;

    function automatic logic is_space(input logic [CpW-1:0] c);
        logic r;
        r = ((c >= 21'h9) && (c <= 21'hD)) || (c == 21'h20) || (c == 21'h1680)
            || ((c >= 21'h2000) && (c <= 21'h2006))
            || ((c >= 21'h2008) && (c <= 21'h200A))
            || (c == 21'h2028) || (c == 21'h2029) || (c == 21'h205F)
            || (c == 21'h3000);
        return r;
    endfunction

    function automatic logic [CpW-1:0] widen(input logic [CpW-1:0] c);
        logic [CpW-1:0] r;
        if ((c < CP_ASCII_LO) || (c > CP_ASCII_HI) || (c == CP_QUOTE) || (c == CP_APOS))
        begin
            r = c;
        end
        else if (c == CP_BACKTICK)
        begin
            r = CP_APOS;
        end
        else
        begin
            r = c + FW_OFFSET;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/ocrfw_front.sv
`timescale 1ns / 1ps
// Front stage: accepts code points, tracks the dot run and turns each item
// into a command for the emitter. Depends on ocrfw_pkg.
module ocrfw_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [ocrfw_pkg::CpW-1:0] code_point,
    input  logic                     final_req,
    output logic                     cmd_valid,
    output ocrfw_pkg::cmd_t          cmd,
    output logic                     dot_idle
);
    import ocrfw_pkg::*;

    typedef enum logic [1:0] {DOT_NONE, DOT_LONE, DOT_RUN} dot_state_t;

    dot_state_t dot_state_reg, dot_state_next;
    logic       pend_period_reg, pend_period_next;
    logic       is_dot;

    always_comb
    begin
        is_dot           = (code_point == CP_PERIOD) || (code_point == CP_MIDDOT);
        cmd              = '0;
        dot_state_next   = dot_state_reg;
        pend_period_next = pend_period_reg;
        if (is_dot)
        begin
            unique case (dot_state_reg)
                DOT_LONE:
                begin
                    cmd.body_cnt     = 2'd2;
                    dot_state_next   = DOT_RUN;
                    pend_period_next = 1'b0;
                end
                DOT_RUN:
                begin
                    cmd.body_cnt = 2'd1;
                end
                default:
                begin
                    if (final_req)
                    begin
                        cmd.body_cnt    = 2'd1;
                        cmd.body_single = 1'b1;
                        cmd.body_cp     = (code_point == CP_PERIOD) ? CP_FW_PERIOD : CP_MIDDOT;
                    end
                    dot_state_next   = DOT_LONE;
                    pend_period_next = (code_point == CP_PERIOD);
                end
            endcase
        end
        else
        begin
            cmd.lead           = (dot_state_reg == DOT_LONE);
            cmd.lead_is_period = pend_period_reg;
            dot_state_next     = DOT_NONE;
            pend_period_next   = 1'b0;
            if (is_space(code_point))
            begin
                cmd.body_cnt = 2'd0;
            end
            else if (code_point == CP_ELLIPSIS)
            begin
                cmd.body_cnt = 2'd3;
            end
            else
            begin
                cmd.body_cnt    = 2'd1;
                cmd.body_single = 1'b1;
                cmd.body_cp     = widen(code_point);
            end
        end
        if (final_req)
        begin
            dot_state_next   = DOT_NONE;
            pend_period_next = 1'b0;
        end
        cmd_valid = accept && (cmd.lead || (cmd.body_cnt != 2'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_state_reg   <= DOT_NONE;
            pend_period_reg <= 1'b0;
        end
        else if (accept)
        begin
            dot_state_reg   <= dot_state_next;
            pend_period_reg <= pend_period_next;
        end
    end

    assign dot_idle = (dot_state_reg == DOT_NONE);

endmodule

FILE: rtl/core/ocrfw_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front stage and the emitter.
// Depends on ocrfw_pkg.
module ocrfw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ocrfw_pkg::cmd_t wr_cmd,
    input  logic            rd_en,
    output ocrfw_pkg::cmd_t rd_cmd,
    output logic            q_full,
    output logic            q_empty
);
    import ocrfw_pkg::*;

    cmd_t             mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_cmd  = mem_reg[rd_ptr_reg];
    assign q_full  = (count_reg == QCntW'(QDepth));
    assign q_empty = (count_reg == '0);

endmodule

FILE: rtl/core/ocrfw_back.sv
`timescale 1ns / 1ps
// Back stage: expands each queued command into result beats and holds
// the current beat in an output register. Depends on ocrfw_pkg.
module ocrfw_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ocrfw_pkg::cmd_t           head,
    input  logic                      q_empty,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [ocrfw_pkg::CpW-1:0] out_code_point,
    output logic                      last_of_item
);
    import ocrfw_pkg::*;

    logic           out_valid_reg;
    logic [CpW-1:0] out_cp_reg;
    logic           out_last_reg;
    logic [1:0]     idx_reg;
    logic [2:0]     total;
    logic [CpW-1:0] beat_cp;
    logic           beat_last;
    logic           load;

    always_comb
    begin
        total = {2'b00, head.lead} + {1'b0, head.body_cnt};
        if (head.lead && (idx_reg == 2'd0))
        begin
            beat_cp = head.lead_is_period ? CP_FW_PERIOD : CP_MIDDOT;
        end
        else
        begin
            beat_cp = head.body_single ? head.body_cp : CP_PERIOD;
        end
        beat_last = ({1'b0, idx_reg} == (total - 3'd1));
        load      = !q_empty && (!out_valid_reg || pop);
        q_pop     = load && beat_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= beat_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_cp_reg   <= beat_cp;
            out_last_reg <= beat_last;
        end
    end

    assign empty          = !out_valid_reg;
    assign out_code_point = out_cp_reg;
    assign last_of_item   = out_last_reg;

endmodule

FILE: rtl/core/ocr_text_fullwidth_normalizer_unit.sv
`timescale 1ns / 1ps
// Top level of the full-width text normalizer: front stage, command queue
// and emitter. Depends on ocrfw_pkg, ocrfw_front, ocrfw_queue and ocrfw_back.
//
//   channel   handshake      beat
//   input     push / full    code_point, final_req
//   result    pop / empty    out_code_point, last_of_item
//
// Items that give one result each stream at one per cycle while pop keeps the
// output register draining. An item that gives several results holds the emitter until all its beats are out;
// the four-entry command queue absorbs that, and full rises when it fills.
// A result passes through the command queue and then the output register before it appears on the ports.
// Reset clears the dot state, the queue and the output valid flag at once.
module ocr_text_fullwidth_normalizer_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [ocrfw_pkg::CpW-1:0] code_point,
    input  logic                      final_req,
    output logic                      empty,
    input  logic                      pop,
    output logic [ocrfw_pkg::CpW-1:0] out_code_point,
    output logic                      last_of_item
);
    import ocrfw_pkg::*;

    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    cmd_t head;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic dot_idle;

    assign full   = q_full;
    assign accept = push && !q_full;

    ocrfw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .code_point (code_point),
        .final_req  (final_req),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .dot_idle   (dot_idle)
    );

    ocrfw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_cmd  (cmd),
        .rd_en   (q_pop),
        .rd_cmd  (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    ocrfw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .out_code_point (out_code_point),
        .last_of_item   (last_of_item)
    );

    a_final_clears_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_req) |=> dot_idle)
        else $error("Dot state not cleared after a final code point.");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("Command queue read while empty.");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !q_full)
        else $error("Command queue written while full.");

endmodule

FILE: bench/ocr_text_fullwidth_normalizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ocr_text_fullwidth_normalizer_unit: a directed table
// followed by random text, with random stalls on both queue sides.
// Depends on ocrfw_pkg and the normalizer RTL.
module ocr_text_fullwidth_normalizer_unit_tb;

    import ocrfw_pkg::*;

    typedef enum logic [1:0] {
        DOTS_NONE = 2'd0,
        DOTS_LONE = 2'd1,
        DOTS_RUN  = 2'd2
    } dot_run_t;

    localparam logic [CpW-1:0] U_PERIOD    = 21'h00002E;
    localparam logic [CpW-1:0] U_MIDDOT    = 21'h0030FB;
    localparam logic [CpW-1:0] U_FW_PERIOD = 21'h00FF0E;
    localparam logic [CpW-1:0] U_ELLIPSIS  = 21'h002026;
    localparam logic [CpW-1:0] U_IDEO_SP   = 21'h003000;
    localparam int             USE_MODEL   = -1;

    typedef struct {
        logic [CpW-1:0] cp;
        logic           fin;
        int             n_typed;
        logic [CpW-1:0] typed[4];
    } text_cp_t;

    typedef struct {
        logic [CpW-1:0] cp;
        logic           last;
    } out_beat_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           push;
    logic           full;
    logic [CpW-1:0] code_point;
    logic           final_req;
    logic           empty;
    logic           pop;
    logic [CpW-1:0] out_code_point;
    logic           last_of_item;

    text_cp_t       text_q[$];
    out_beat_t      expected_q[$];
    dot_run_t       dot_run;
    logic           held_is_period;
    int             error_count = 0;
    int             accepted_items = 0;
    bit             rx_holding = 1'b0;

    ocr_text_fullwidth_normalizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .code_point     (code_point),
        .final_req      (final_req),
        .empty          (empty),
        .pop            (pop),
        .out_code_point (out_code_point),
        .last_of_item   (last_of_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit is_blank(input logic [CpW-1:0] c);
        return (c >= 21'h9 && c <= 21'hD) || c == 21'h20 || c == 21'h1680
            || (c >= 21'h2000 && c <= 21'h2006) || (c >= 21'h2008 && c <= 21'h200A)
            || c == 21'h2028 || c == 21'h2029 || c == 21'h205F || c == U_IDEO_SP;
    endfunction

    function automatic logic [CpW-1:0] to_fullwidth(input logic [CpW-1:0] c);
        if (c < 21'h21 || c > 21'h7E || c == 21'h22 || c == 21'h27)
        begin
            return c;
        end
        if (c == 21'h60)
        begin
            return 21'h27;
        end
        return c + 21'hFEE0;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
        begin
            return $urandom_range(0, 2);
        end
        if (sel < 19)
        begin
            return $urandom_range(3, 9);
        end
        return $urandom_range(20, 40);
    endfunction

    // Advances the dot state by one code point and returns the number of normalized results, written to res.
    function automatic int normalize_cp(input logic [CpW-1:0] c, input logic fin,
                                        output logic [CpW-1:0] res[4]);
        int n;
        n = 0;
        if (c == U_PERIOD || c == U_MIDDOT)
        begin
            if (dot_run == DOTS_LONE)
            begin
                res[0] = U_PERIOD;
                res[1] = U_PERIOD;
                n = 2;
                dot_run = DOTS_RUN;
                held_is_period = 1'b0;
            end
            else if (dot_run == DOTS_RUN)
            begin
                res[0] = U_PERIOD;
                n = 1;
            end
            else
            begin
                dot_run = DOTS_LONE;
                held_is_period = (c == U_PERIOD);
            end
        end
        else
        begin
            if (dot_run == DOTS_LONE)
            begin
                res[n] = held_is_period ? U_FW_PERIOD : U_MIDDOT;
                n++;
            end
            dot_run = DOTS_NONE;
            held_is_period = 1'b0;
            if (c == U_ELLIPSIS)
            begin
                res[n] = U_PERIOD;
                res[n + 1] = U_PERIOD;
                res[n + 2] = U_PERIOD;
                n += 3;
            end
            else if (!is_blank(c))
            begin
                res[n] = to_fullwidth(c);
                n++;
            end
        end
        if (fin)
        begin
            if (dot_run == DOTS_LONE)
            begin
                res[n] = held_is_period ? U_FW_PERIOD : U_MIDDOT;
                n++;
            end
            dot_run = DOTS_NONE;
            held_is_period = 1'b0;
        end
        return n;
    endfunction

    task automatic add_text(input logic [CpW-1:0] c, input logic fin, input int n,
                            input logic [CpW-1:0] r0 = '0, input logic [CpW-1:0] r1 = '0,
                            input logic [CpW-1:0] r2 = '0, input logic [CpW-1:0] r3 = '0);
        text_cp_t t;
        t.cp = c;
        t.fin = fin;
        t.n_typed = n;
        t.typed[0] = r0;
        t.typed[1] = r1;
        t.typed[2] = r2;
        t.typed[3] = r3;
        text_q.push_back(t);
    endtask

    task automatic add_random_text();
        logic [CpW-1:0] blanks[17];
        logic [CpW-1:0] odd[10];
        int             sel;
        int             run;
        logic [CpW-1:0] c;
        blanks = '{21'h9, 21'hA, 21'hB, 21'hC, 21'hD, 21'h20, 21'h1680, 21'h2000,
                   21'h2003, 21'h2006, 21'h2008, 21'h200A, 21'h2028, 21'h2029,
                   21'h205F, U_IDEO_SP, 21'h2001};
        odd = '{21'h22, 21'h27, 21'h60, 21'h10FFFF, 21'h1FFFFF, 21'h2007, 21'h200B,
                21'hD800, 21'hDFFF, 21'h110000};
        while (text_q.size() < 270)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                add_text(CpW'($urandom_range(21'h21, 21'h7E)), $urandom_range(0, 11) == 0,
                         USE_MODEL);
            end
            else if (sel < 45)
            begin
                run = $urandom_range(1, 4);
                repeat (run)
                begin
                    c = $urandom_range(0, 1) ? U_PERIOD : U_MIDDOT;
                    add_text(c, $urandom_range(0, 9) == 0, USE_MODEL);
                end
            end
            else if (sel < 53)
            begin
                add_text(blanks[$urandom_range(0, 16)], $urandom_range(0, 7) == 0,
                         USE_MODEL);
            end
            else if (sel < 57)
            begin
                add_text(U_ELLIPSIS, $urandom_range(0, 5) == 0, USE_MODEL);
            end
            else if (sel < 65)
            begin
                c = ($urandom_range(0, 5) == 0) ? 21'h7F : CpW'($urandom_range(0, 21'h20));
                add_text(c, $urandom_range(0, 11) == 0, USE_MODEL);
            end
            else if (sel < 80)
            begin
                add_text(CpW'($urandom_range(21'h80, 21'hFFFF)), $urandom_range(0, 11) == 0,
                         USE_MODEL);
            end
            else if (sel < 92)
            begin
                add_text(CpW'($urandom & 21'h1FFFFF), $urandom_range(0, 11) == 0, USE_MODEL);
            end
            else
            begin
                add_text(odd[$urandom_range(0, 9)], $urandom_range(0, 11) == 0,
                         USE_MODEL);
            end
        end
    endtask

    task automatic log_accepted(input text_cp_t t);
        logic [CpW-1:0] res[4];
        int             n;
        out_beat_t      b;
        n = normalize_cp(t.cp, t.fin, res);
        if (t.n_typed != USE_MODEL)
        begin
            n = t.n_typed;
            res = t.typed;
        end
        for (int i = 0; i < n; i++)
        begin
            b.cp = res[i];
            b.last = (i == n - 1);
            expected_q.push_back(b);
        end
        accepted_items++;
    endtask

    task automatic send_beat(input text_cp_t t);
        push <= 1'b1;
        code_point <= t.cp;
        final_req <= t.fin;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        log_accepted(t);
    endtask

    task automatic check_result();
        out_beat_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, actual %h last %b", $time, out_code_point,
                     last_of_item);
            error_count++;
            return;
        end
        e = expected_q.pop_front();
        if (out_code_point !== e.cp)
        begin
            $display("%0t: out_code_point expected %h actual %h", $time, e.cp,
                     out_code_point);
            error_count++;
        end
        if (last_of_item !== e.last)
        begin
            $display("%0t: last_of_item expected %b actual %b", $time, e.last,
                     last_of_item);
            error_count++;
        end
    endtask

    initial
    begin : receiver
        int stall_left;
        bit calm;
        bit held_once;
        stall_left = 0;
        calm = 1'b0;
        held_once = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_result();
            end
            if (!held_once && accepted_items >= 40)
            begin
                held_once = 1'b1;
                rx_holding = 1'b1;
                stall_left = 60;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rx_holding = rx_holding && (stall_left > 0);
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
            begin
                calm = !calm;
            end
        end
    end

    initial
    begin : sender
        int gap;
        bit calm;
        calm = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        code_point = '0;
        final_req = 1'b0;
        dot_run = DOTS_NONE;
        held_is_period = 1'b0;

        add_text(21'h41, 1'b0, 1, 21'hFF21);
        add_text(21'h21, 1'b0, 1, 21'hFF01);
        add_text(21'h7E, 1'b0, 1, 21'hFF5E);
        add_text(21'h22, 1'b0, 1, 21'h22);
        add_text(21'h27, 1'b0, 1, 21'h27);
        add_text(21'h60, 1'b0, 1, 21'h27);
        add_text(21'h20, 1'b0, 0);
        add_text(U_ELLIPSIS, 1'b0, 3, U_PERIOD, U_PERIOD, U_PERIOD);
        add_text(U_PERIOD, 1'b0, 0);
        add_text(21'h42, 1'b0, 2, U_FW_PERIOD, 21'hFF22);
        add_text(U_MIDDOT, 1'b0, 0);
        add_text(U_IDEO_SP, 1'b0, 1, U_MIDDOT);
        add_text(U_PERIOD, 1'b0, 0);
        add_text(U_MIDDOT, 1'b0, 2, U_PERIOD, U_PERIOD);
        add_text(U_PERIOD, 1'b0, 1, U_PERIOD);
        add_text(21'h78, 1'b1, 1, 21'hFF58);
        add_text(U_PERIOD, 1'b1, 1, U_FW_PERIOD);
        add_text(U_MIDDOT, 1'b1, 1, U_MIDDOT);
        add_text(U_PERIOD, 1'b0, 0);
        add_text(U_ELLIPSIS, 1'b1, 4, U_FW_PERIOD, U_PERIOD, U_PERIOD, U_PERIOD);
        add_text(21'h1FFFFF, 1'b0, 1, 21'h1FFFFF);
        add_text(21'hD800, 1'b0, 1, 21'hD800);
        add_text(21'h0, 1'b0, 1, 21'h0);
        add_text(21'h7F, 1'b0, 1, 21'h7F);
        add_text(U_PERIOD, 1'b0, 0);
        add_text(U_PERIOD, 1'b1, 2, U_PERIOD, U_PERIOD);
        add_text(21'h10FFFF, 1'b1, 1, 21'h10FFFF);
        add_random_text();

        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        for (int i = 0; i < text_q.size(); i++)
        begin
            send_beat(text_q[i]);
            gap = (calm || rx_holding) ? 0 : pick_gap();
            if ($urandom_range(0, 49) == 0)
            begin
                calm = !calm;
            end
            if (gap > 0 || i == text_q.size() - 1)
            begin
                push <= 1'b0;
                repeat (gap)
                begin
                    @(posedge clk);
                end
            end
        end

        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10)
        begin
            @(posedge clk);
        end
        if (error_count == 0 && expected_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/ocrfw_pkg.sv
rtl/core/ocrfw_front.sv
rtl/core/ocrfw_queue.sv
rtl/core/ocrfw_back.sv
rtl/core/ocr_text_fullwidth_normalizer_unit.sv
bench/ocr_text_fullwidth_normalizer_unit_tb.sv
